/* hdl/scp_pkg.sv */
// shared types, constants and selector decode for the system control coprocessor
package scp_pkg;

  localparam int unsigned SelW       = 14;
  localparam int unsigned PlainCount = 29;
  localparam int unsigned SlotW      = 5;
  localparam int unsigned FsrW       = 12;

  localparam logic [SlotW-1:0] SlotDfsr = 5'd19;
  localparam logic [SlotW-1:0] SlotIfsr = 5'd20;
  localparam logic [SlotW-1:0] SlotDfar = 5'd21;
  localparam logic [SlotW-1:0] SlotIfar = 5'd22;

  localparam logic [31:0] CtrlVeBit    = 32'h0100_0000;
  localparam logic [31:0] CtrlVhBit    = 32'h0000_2000;
  localparam logic [31:0] CtrlForceBit = 32'h0040_0000;
  localparam logic [31:0] AsidMask     = 32'h0000_00ff;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_ABORT = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_UNALIGNED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ERR,
    OP_CONST_RD,
    OP_PLAIN_RD,
    OP_PLAIN_WR,
    OP_SYS_RD,
    OP_SYS_WR,
    OP_ABORT
  } op_e;

  typedef enum logic [2:0] {
    SYS_SCTLR,
    SYS_TTBR0,
    SYS_TTBR1,
    SYS_TTBCR,
    SYS_DACR,
    SYS_CTXID
  } sys_e;

  typedef struct packed {
    op_e              op;
    sys_e             sys;
    logic [SlotW-1:0] slot;
    logic [31:0]      data;
    logic [FsrW-1:0]  fsr;
  } item_t;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] slot;
  } plain_hit_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
  } id_hit_t;

  typedef struct packed {
    logic hit;
    sys_e sys;
  } sys_hit_t;

  function automatic logic [SelW-1:0] sel(input logic [3:0] n, input logic [2:0] o1,
                                          input logic [3:0] m, input logic [2:0] o2);
    sel = {n, o1, m, o2};
  endfunction

  localparam logic [SelW-1:0] PlainSel [PlainCount] = '{
    {4'd7, 3'd0, 4'd5, 3'd0},  {4'd7, 3'd0, 4'd5, 3'd1},
    {4'd7, 3'd0, 4'd5, 3'd6},  {4'd7, 3'd0, 4'd5, 3'd7},
    {4'd7, 3'd0, 4'd5, 3'd4},  {4'd7, 3'd0, 4'd10, 3'd1},
    {4'd7, 3'd0, 4'd10, 3'd4}, {4'd7, 3'd0, 4'd10, 3'd5},
    {4'd7, 3'd0, 4'd11, 3'd1}, {4'd7, 3'd0, 4'd14, 3'd1},
    {4'd8, 3'd0, 4'd5, 3'd0},  {4'd8, 3'd0, 4'd5, 3'd1},
    {4'd8, 3'd0, 4'd5, 3'd2},  {4'd8, 3'd0, 4'd6, 3'd0},
    {4'd8, 3'd0, 4'd6, 3'd1},  {4'd8, 3'd0, 4'd6, 3'd2},
    {4'd8, 3'd0, 4'd7, 3'd0},  {4'd8, 3'd0, 4'd7, 3'd1},
    {4'd8, 3'd0, 4'd7, 3'd2},  {4'd5, 3'd0, 4'd0, 3'd0},
    {4'd5, 3'd0, 4'd0, 3'd1},  {4'd6, 3'd0, 4'd0, 3'd0},
    {4'd6, 3'd0, 4'd0, 3'd2},  {4'd10, 3'd0, 4'd2, 3'd0},
    {4'd10, 3'd0, 4'd2, 3'd1}, {4'd0, 3'd2, 4'd0, 3'd0},
    {4'd1, 3'd0, 4'd0, 3'd2},  {4'd13, 3'd0, 4'd0, 3'd2},
    {4'd13, 3'd0, 4'd0, 3'd3}
  };

  function automatic plain_hit_t plain_lookup(input logic [SelW-1:0] s);
    plain_hit_t r;
    r = '0;
    for (int i = 0; i < PlainCount; i++) begin
      if (PlainSel[i] == s) begin
        r.hit  = 1'b1;
        r.slot = SlotW'(i);
      end
    end
    plain_lookup = r;
  endfunction

  function automatic id_hit_t id_lookup(input logic [SelW-1:0] s);
    id_hit_t r;
    r.hit   = 1'b1;
    r.value = '0;
    case (s)
      sel(4'd0, 3'd0, 4'd0, 3'd0): r.value = 32'd1092612097;
      sel(4'd0, 3'd0, 4'd0, 3'd1): r.value = 32'd2147500032;
      sel(4'd0, 3'd0, 4'd1, 3'd0): r.value = 32'd1;
      sel(4'd0, 3'd0, 4'd1, 3'd4): r.value = 32'd65539;
      sel(4'd0, 3'd0, 4'd1, 3'd5): r.value = 32'd0;
      sel(4'd0, 3'd0, 4'd2, 3'd0): r.value = 32'd65539;
      sel(4'd0, 3'd1, 4'd0, 3'd0): r.value = 32'd4026531848;
      sel(4'd0, 3'd1, 4'd0, 3'd1): r.value = 32'd0;
      default:                     r.hit   = 1'b0;
    endcase
    id_lookup = r;
  endfunction

  function automatic sys_hit_t sys_lookup(input logic [SelW-1:0] s);
    sys_hit_t r;
    r.hit = 1'b1;
    r.sys = SYS_SCTLR;
    case (s)
      sel(4'd1, 3'd0, 4'd0, 3'd0):  r.sys = SYS_SCTLR;
      sel(4'd2, 3'd0, 4'd0, 3'd0):  r.sys = SYS_TTBR0;
      sel(4'd2, 3'd0, 4'd0, 3'd1):  r.sys = SYS_TTBR1;
      sel(4'd2, 3'd0, 4'd0, 3'd2):  r.sys = SYS_TTBCR;
      sel(4'd3, 3'd0, 4'd0, 3'd0):  r.sys = SYS_DACR;
      sel(4'd13, 3'd0, 4'd0, 3'd1): r.sys = SYS_CTXID;
      default:                      r.hit = 1'b0;
    endcase
    sys_lookup = r;
  endfunction

endpackage

/* hdl/scp_front.sv */
// front end: takes request items and decodes the register selector into an operation
module scp_front (
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [95:0]                 s_axis_tdata,
  input  logic [1:0]                  s_axis_tuser,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output scp_pkg::item_t              q_item_o
);

  logic [3:0]                 crn;
  logic [2:0]                 opc1;
  logic [3:0]                 crm;
  logic [2:0]                 opc2;
  logic [31:0]                write_data;
  logic [31:0]                fault_address;
  logic [9:0]                 fault_status;
  logic                       fault_is_write;
  logic [scp_pkg::SelW-1:0]   sel;
  scp_pkg::plain_hit_t        plain_hit;
  scp_pkg::id_hit_t           id_hit;
  scp_pkg::sys_hit_t          sys_hit;

  assign crn            = s_axis_tdata[3:0];
  assign opc1           = s_axis_tdata[6:4];
  assign crm            = s_axis_tdata[10:7];
  assign opc2           = s_axis_tdata[13:11];
  assign write_data     = s_axis_tdata[45:14];
  assign fault_address  = s_axis_tdata[77:46];
  assign fault_status   = s_axis_tdata[87:78];
  assign fault_is_write = s_axis_tdata[88];

  assign sel       = scp_pkg::sel(crn, opc1, crm, opc2);
  assign plain_hit = scp_pkg::plain_lookup(sel);
  assign id_hit    = scp_pkg::id_lookup(sel);
  assign sys_hit   = scp_pkg::sys_lookup(sel);

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  always_comb begin
    q_item_o      = '0;
    q_item_o.op   = scp_pkg::OP_NOP;
    q_item_o.sys  = sys_hit.sys;
    q_item_o.slot = plain_hit.slot;
    case (scp_pkg::req_e'(s_axis_tuser))
      scp_pkg::REQ_READ: begin
        if (plain_hit.hit) begin
          q_item_o.op = scp_pkg::OP_PLAIN_RD;
        end else if (id_hit.hit) begin
          q_item_o.op   = scp_pkg::OP_CONST_RD;
          q_item_o.data = id_hit.value;
        end else if (sys_hit.hit) begin
          q_item_o.op = scp_pkg::OP_SYS_RD;
        end else begin
          q_item_o.op = scp_pkg::OP_ERR;
        end
      end
      scp_pkg::REQ_WRITE: begin
        q_item_o.data = write_data;
        if (plain_hit.hit) begin
          q_item_o.op = scp_pkg::OP_PLAIN_WR;
        end else if (sys_hit.hit) begin
          q_item_o.op = scp_pkg::OP_SYS_WR;
        end else begin
          q_item_o.op = scp_pkg::OP_ERR;
        end
      end
      scp_pkg::REQ_ABORT: begin
        q_item_o.op   = scp_pkg::OP_ABORT;
        q_item_o.data = fault_address;
        q_item_o.fsr  = {fault_is_write, 1'b0, fault_status};
      end
      default: begin
        q_item_o.op = scp_pkg::OP_NOP;
      end
    endcase
  end

endmodule

/* hdl/scp_queue.sv */
// small first-in first-out queue of decoded operations between front and back
module scp_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scp_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output scp_pkg::item_t head_o
);

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  scp_pkg::item_t    mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;

  assign full_o  = (count_q == CountW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* hdl/scp_back.sv */
// back end: register file, operation execute and result register
module scp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         walk_width_i,
  input  logic               q_empty_i,
  input  scp_pkg::item_t     q_head_i,
  output logic               q_pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [111:0]       m_axis_tdata,
  output logic [1:0]         m_axis_tuser
);

  logic [31:0]       plain_q [scp_pkg::PlainCount];
  logic [31:0]       plain_wdata;
  logic              plain_we;
  logic              abort_we;
  logic [31:0]       ctrl_q, ctrl_d;
  logic [31:0]       ttbr0_q, ttbr0_d;
  logic [31:0]       ttbr1_q, ttbr1_d;
  logic [31:0]       ttbcr_q, ttbcr_d;
  logic [31:0]       dacr_q, dacr_d;
  logic [31:0]       ctxid_q, ctxid_d;
  logic              mmu_on_q, mmu_on_d;
  logic              align_q, align_d;
  logic              vec_high_q, vec_high_d;
  logic [31:0]       walk_base_q, walk_base_d;
  logic [7:0]        asid_q, asid_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       rdata_q, rdata_d;
  scp_pkg::status_e  status_q, status_d;
  logic [3:0]        keep_from;
  logic [31:0]       base_mask;
  logic [31:0]       sys_rdata;
  scp_pkg::item_t    it;

  assign it        = q_head_i;
  assign q_pop_o   = !q_empty_i && (!out_valid_q || m_axis_tready);
  assign keep_from = 4'd14 - {1'b0, walk_width_i};
  assign base_mask = 32'hffff_ffff << keep_from;

  always_comb begin
    case (it.sys)
      scp_pkg::SYS_SCTLR: sys_rdata = ctrl_q;
      scp_pkg::SYS_TTBR0: sys_rdata = ttbr0_q;
      scp_pkg::SYS_TTBR1: sys_rdata = ttbr1_q;
      scp_pkg::SYS_TTBCR: sys_rdata = ttbcr_q;
      scp_pkg::SYS_DACR:  sys_rdata = dacr_q;
      scp_pkg::SYS_CTXID: sys_rdata = ctxid_q;
      default:            sys_rdata = '0;
    endcase
  end

  always_comb begin
    ctrl_d      = ctrl_q;
    ttbr0_d     = ttbr0_q;
    ttbr1_d     = ttbr1_q;
    ttbcr_d     = ttbcr_q;
    dacr_d      = dacr_q;
    ctxid_d     = ctxid_q;
    mmu_on_d    = mmu_on_q;
    align_d     = align_q;
    vec_high_d  = vec_high_q;
    walk_base_d = walk_base_q;
    asid_d      = asid_q;
    plain_we    = 1'b0;
    abort_we    = 1'b0;
    plain_wdata = it.data;
    rdata_d     = rdata_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (q_pop_o) begin
      out_valid_d = 1'b1;
      rdata_d     = '0;
      status_d    = scp_pkg::ST_OK;
      case (it.op)
        scp_pkg::OP_ERR: begin
          status_d = scp_pkg::ST_UNKNOWN;
        end
        scp_pkg::OP_CONST_RD: begin
          rdata_d = it.data;
        end
        scp_pkg::OP_PLAIN_RD: begin
          rdata_d = plain_q[it.slot];
        end
        scp_pkg::OP_PLAIN_WR: begin
          plain_we = 1'b1;
        end
        scp_pkg::OP_SYS_RD: begin
          rdata_d = sys_rdata;
        end
        scp_pkg::OP_SYS_WR: begin
          case (it.sys)
            scp_pkg::SYS_SCTLR: begin
              mmu_on_d = it.data[0];
              align_d  = it.data[1];
              if ((it.data & scp_pkg::CtrlVeBit) == '0) begin
                vec_high_d = |(it.data & scp_pkg::CtrlVhBit);
              end
              if (it.data[1]) begin
                ctrl_d   = it.data;
                status_d = scp_pkg::ST_UNALIGNED;
              end else begin
                ctrl_d = it.data | scp_pkg::CtrlForceBit;
              end
            end
            scp_pkg::SYS_TTBR0: begin
              ttbr0_d     = it.data;
              walk_base_d = it.data & base_mask;
            end
            scp_pkg::SYS_TTBR1: begin
              ttbr1_d     = it.data;
              walk_base_d = it.data & base_mask;
            end
            scp_pkg::SYS_TTBCR: begin
              ttbcr_d     = it.data;
              walk_base_d = it.data & base_mask;
            end
            scp_pkg::SYS_DACR: begin
              dacr_d = it.data;
            end
            scp_pkg::SYS_CTXID: begin
              ctxid_d = it.data;
              asid_d  = 8'(it.data & scp_pkg::AsidMask);
            end
            default: begin
              status_d = scp_pkg::ST_UNKNOWN;
            end
          endcase
        end
        scp_pkg::OP_ABORT: begin
          abort_we = 1'b1;
        end
        default: begin
          status_d = scp_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < scp_pkg::PlainCount; i++) begin
        plain_q[i] <= '0;
      end
    end else if (plain_we) begin
      plain_q[it.slot] <= plain_wdata;
    end else if (abort_we) begin
      plain_q[scp_pkg::SlotDfar] <= it.data;
      plain_q[scp_pkg::SlotIfar] <= it.data;
      plain_q[scp_pkg::SlotDfsr] <= 32'(it.fsr);
      plain_q[scp_pkg::SlotIfsr] <= 32'(it.fsr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      ttbr0_q     <= '0;
      ttbr1_q     <= '0;
      ttbcr_q     <= '0;
      dacr_q      <= '0;
      ctxid_q     <= '0;
      mmu_on_q    <= 1'b0;
      align_q     <= 1'b0;
      vec_high_q  <= 1'b0;
      walk_base_q <= '0;
      asid_q      <= '0;
      out_valid_q <= 1'b0;
      rdata_q     <= '0;
      status_q    <= scp_pkg::ST_OK;
    end else begin
      ctrl_q      <= ctrl_d;
      ttbr0_q     <= ttbr0_d;
      ttbr1_q     <= ttbr1_d;
      ttbcr_q     <= ttbcr_d;
      dacr_q      <= dacr_d;
      ctxid_q     <= ctxid_d;
      mmu_on_q    <= mmu_on_d;
      align_q     <= align_d;
      vec_high_q  <= vec_high_d;
      walk_base_q <= walk_base_d;
      asid_q      <= asid_d;
      out_valid_q <= out_valid_d;
      rdata_q     <= rdata_d;
      status_q    <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {4'b0, ctrl_q[27], dacr_q, asid_q, walk_base_q,
                          vec_high_q, align_q, mmu_on_q, rdata_q};

endmodule

/* hdl/system_control_coprocessor_regs_top.sv */
// top level of the system control coprocessor register file
// an accepted item is written into the queue, then popped into the result register that drives m_axis_tvalid
// throughput: one item per cycle while the queue is not full; the result register stalls only on m_axis_tready
// a queue of QueueDepth decoded items lets the front keep accepting during output stalls
// reset: all registers, table walk width and queue state clear to zero; no clearing pass
module system_control_coprocessor_regs_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // crn, opc1, crm, opc2, write_data, fault_address, fault_status, fault_is_write, zero pad
  input  logic [95:0]  s_axis_tdata,
  // req_type
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // read_data, mmu_enable, align_check, high_vectors, translation_base,
  // address_space_id, domain_access, nmfi, zero pad
  output logic [111:0] m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser
);

  logic           walk_width_we;
  logic [2:0]     walk_width_q;
  logic           q_full;
  logic           q_push;
  logic           q_empty;
  logic           q_pop;
  scp_pkg::item_t q_push_item;
  scp_pkg::item_t q_head;

  assign cfg_ready_o   = 1'b1;
  assign walk_width_we = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_width_q <= '0;
    end else if (walk_width_we) begin
      walk_width_q <= cfg_data_i;
    end
  end

  scp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_push_item)
  );

  scp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  scp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .walk_width_i  (walk_width_q),
    .q_empty_i     (q_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
